// File: design/swdh_pkg.sv
// Shared types, codes and helpers of the SWD host transfer engine.
// Used by swdh_seq and swd_host_transfer_engine; no dependencies.
package swdh_pkg;

   localparam int unsigned LINE_RESET_CYCLES = 64;
   localparam logic [15:0] SWITCH_WORD       = 16'hE79E;

   localparam int unsigned REQ_BITS  = 8;
   localparam int unsigned DATA_BITS = 32;
   localparam int unsigned ACK_BITS  = 3;

   // Bit counter must hold the longest phase: the idle phase, set by the 8-bit idle_bits.
   localparam int unsigned CNT_W = 8;

   localparam logic [2:0] ACK_OK    = 3'd1;
   localparam logic [2:0] ACK_WAIT  = 3'd2;
   localparam logic [2:0] ACK_FAULT = 3'd4;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_WAIT_LIMIT = 3'd1;
   localparam logic [2:0] ST_FAULT      = 3'd2;
   localparam logic [2:0] ST_PARITY     = 3'd3;
   localparam logic [2:0] ST_BAD_ACK    = 3'd4;

   localparam logic CSR_RETRY_LIMIT = 1'b0;
   localparam logic CSR_IDLE_BITS   = 1'b1;

   localparam logic [6:0] RETRY_LIMIT_RESET = 7'd64;
   localparam logic [7:0] IDLE_BITS_RESET   = 8'd8;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_START   = 2'd1,
      OP_CONNECT = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_REQ      = 4'd1,
      PH_TRN_ACK  = 4'd2,
      PH_ACK      = 4'd3,
      PH_RDATA    = 4'd4,
      PH_RPAR     = 4'd5,
      PH_TRN_END  = 4'd6,
      PH_TRN_PERR = 4'd7,
      PH_TRN_W    = 4'd8,
      PH_WDATA    = 4'd9,
      PH_WPAR     = 4'd10,
      PH_IDLEB    = 4'd11,
      PH_LR1      = 4'd12,
      PH_SWITCH   = 4'd13,
      PH_LR2      = 4'd14,
      PH_CIDLE    = 4'd15
   } phase_type;

   // One accepted item as seen by the sequencer.
   typedef struct packed {
      logic        step;
      logic [1:0]  opcode;
      logic        ap_not_dp;
      logic        read_not_write;
      logic [1:0]  reg_addr;
      logic [31:0] write_data;
      logic        swdio_sample;
   } item_type;

   // One result, in the bit order of the result channel's tdata.
   typedef struct packed {
      logic [31:0] read_data;
      logic [2:0]  status;
      logic        done_res;
      logic        busy_res;
      logic        swdio_enable;
      logic        swdio_drive;
      logic        line_clocked;
   } result_type;

   // Request header, sent LSB first: start, APnDP, RnW, A[3:2], parity, stop, park.
   function automatic logic [7:0] request_byte(input logic ap, input logic rnw,
                                                input logic [1:0] addr);
      logic par;
      par = ap ^ rnw ^ addr[0] ^ addr[1];
      return {1'b1, 1'b0, par, addr, rnw, ap, 1'b1};
   endfunction

   // Final status of an attempt that is not retried.
   function automatic logic [2:0] ack_status(input logic [2:0] ack);
      logic [2:0] st;
      if (ack == ACK_OK) st = ST_OK;
      else if (ack == ACK_WAIT) st = ST_WAIT_LIMIT;
      else if (ack == ACK_FAULT) st = ST_FAULT;
      else st = ST_BAD_ACK;
      return st;
   endfunction

endpackage

// File: design/swdh_seq.sv
// Wire sequencer of the SWD host engine: phase state, counters and latched request.
// Advances one SWCLK cycle per tick item unless idle. Depends on swdh_pkg.
module swdh_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  swdh_pkg::item_type     item,
   input  logic [6:0]             retry_limit,
   input  logic [7:0]             idle_bits,
   output swdh_pkg::result_type   result
);

   swdh_pkg::phase_type phase_ff, phase_in;
   logic [swdh_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0] shift_ff, shift_in;
   logic        lat_ap_ff, lat_ap_in;
   logic        lat_read_ff, lat_read_in;
   logic [1:0]  lat_addr_ff, lat_addr_in;
   logic [31:0] lat_wdata_ff, lat_wdata_in;
   logic [2:0]  ack_ff, ack_in;
   logic [6:0]  attempt_ff, attempt_in;
   logic [2:0]  status_ff, status_in;
   logic [31:0] last_read_ff, last_read_in;

   logic [swdh_pkg::CNT_W:0] cnt_inc;
   logic        wait_retry;
   logic        clocked, busy, done;
   logic        drive, enable;
   logic [7:0]  req_byte;

   assign cnt_inc    = {1'b0, cnt_ff} + 1'b1;
   assign wait_retry = (ack_ff == swdh_pkg::ACK_WAIT) && (attempt_ff < retry_limit);
   assign req_byte   = swdh_pkg::request_byte(lat_ap_ff, lat_read_ff, lat_addr_ff);

   // Next state.
   always_comb begin
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      shift_in     = shift_ff;
      lat_ap_in    = lat_ap_ff;
      lat_read_in  = lat_read_ff;
      lat_addr_in  = lat_addr_ff;
      lat_wdata_in = lat_wdata_ff;
      ack_in       = ack_ff;
      attempt_in   = attempt_ff;
      status_in    = status_ff;
      last_read_in = last_read_ff;
      clocked      = 1'b0;
      busy         = 1'b0;
      done         = 1'b0;

      if (item.step) begin
         unique case (item.opcode)
            swdh_pkg::OP_TICK: begin
               if (phase_ff != swdh_pkg::PH_IDLE) begin
                  clocked = 1'b1;
                  busy    = 1'b1;
                  unique case (phase_ff)
                     swdh_pkg::PH_IDLE: begin
                        phase_in = swdh_pkg::PH_IDLE;
                     end
                     swdh_pkg::PH_REQ: begin
                        cnt_in = cnt_inc[swdh_pkg::CNT_W-1:0];
                        if (cnt_inc >= (swdh_pkg::CNT_W+1)'(swdh_pkg::REQ_BITS)) begin
                           phase_in = swdh_pkg::PH_TRN_ACK;
                           cnt_in   = '0;
                        end
                     end
                     swdh_pkg::PH_TRN_ACK: begin
                        phase_in = swdh_pkg::PH_ACK;
                        cnt_in   = '0;
                        ack_in   = '0;
                     end
                     swdh_pkg::PH_ACK: begin
                        ack_in = ack_ff | (3'(item.swdio_sample) << cnt_ff[1:0]);
                        cnt_in = cnt_inc[swdh_pkg::CNT_W-1:0];
                        if (cnt_inc >= (swdh_pkg::CNT_W+1)'(swdh_pkg::ACK_BITS)) begin
                           cnt_in = '0;
                           if (attempt_ff != 7'h7F) attempt_in = attempt_ff + 7'd1;
                           if (ack_in == swdh_pkg::ACK_OK) begin
                              if (lat_read_ff) begin
                                 phase_in = swdh_pkg::PH_RDATA;
                                 shift_in = '0;
                              end else begin
                                 phase_in = swdh_pkg::PH_TRN_W;
                              end
                           end else begin
                              phase_in = swdh_pkg::PH_TRN_END;
                           end
                        end
                     end
                     swdh_pkg::PH_RDATA: begin
                        shift_in[cnt_ff[4:0]] = shift_ff[cnt_ff[4:0]] | item.swdio_sample;
                        cnt_in = cnt_inc[swdh_pkg::CNT_W-1:0];
                        if (cnt_inc >= (swdh_pkg::CNT_W+1)'(swdh_pkg::DATA_BITS)) begin
                           phase_in = swdh_pkg::PH_RPAR;
                           cnt_in   = '0;
                        end
                     end
                     swdh_pkg::PH_RPAR: begin
                        if (item.swdio_sample == ^shift_ff) begin
                           last_read_in = shift_ff;
                           phase_in     = swdh_pkg::PH_TRN_END;
                        end else begin
                           phase_in = swdh_pkg::PH_TRN_PERR;
                        end
                     end
                     swdh_pkg::PH_TRN_END, swdh_pkg::PH_WPAR: begin
                        cnt_in = '0;
                        if (idle_bits != 8'd0) begin
                           phase_in = swdh_pkg::PH_IDLEB;
                        end else if (wait_retry) begin
                           phase_in = swdh_pkg::PH_REQ;
                        end else begin
                           status_in = swdh_pkg::ack_status(ack_ff);
                           phase_in  = swdh_pkg::PH_IDLE;
                           done      = 1'b1;
                        end
                     end
                     swdh_pkg::PH_TRN_PERR: begin
                        status_in = swdh_pkg::ST_PARITY;
                        phase_in  = swdh_pkg::PH_IDLE;
                        cnt_in    = '0;
                        done      = 1'b1;
                     end
                     swdh_pkg::PH_TRN_W: begin
                        shift_in = lat_wdata_ff;
                        phase_in = swdh_pkg::PH_WDATA;
                        cnt_in   = '0;
                     end
                     swdh_pkg::PH_WDATA: begin
                        cnt_in = cnt_inc[swdh_pkg::CNT_W-1:0];
                        if (cnt_inc >= (swdh_pkg::CNT_W+1)'(swdh_pkg::DATA_BITS)) begin
                           phase_in = swdh_pkg::PH_WPAR;
                           cnt_in   = '0;
                        end
                     end
                     swdh_pkg::PH_IDLEB: begin
                        cnt_in = cnt_inc[swdh_pkg::CNT_W-1:0];
                        if (cnt_inc >= {1'b0, idle_bits}) begin
                           cnt_in = '0;
                           if (wait_retry) begin
                              phase_in = swdh_pkg::PH_REQ;
                           end else begin
                              status_in = swdh_pkg::ack_status(ack_ff);
                              phase_in  = swdh_pkg::PH_IDLE;
                              done      = 1'b1;
                           end
                        end
                     end
                     swdh_pkg::PH_LR1, swdh_pkg::PH_LR2: begin
                        cnt_in = cnt_inc[swdh_pkg::CNT_W-1:0];
                        if (cnt_inc >= (swdh_pkg::CNT_W+1)'(swdh_pkg::LINE_RESET_CYCLES)) begin
                           cnt_in = '0;
                           if (phase_ff == swdh_pkg::PH_LR1) phase_in = swdh_pkg::PH_SWITCH;
                           else if (idle_bits == 8'd0) phase_in = swdh_pkg::PH_REQ;
                           else phase_in = swdh_pkg::PH_CIDLE;
                        end
                     end
                     swdh_pkg::PH_SWITCH: begin
                        cnt_in = cnt_inc[swdh_pkg::CNT_W-1:0];
                        if (cnt_inc >= (swdh_pkg::CNT_W+1)'(16)) begin
                           phase_in = swdh_pkg::PH_LR2;
                           cnt_in   = '0;
                        end
                     end
                     swdh_pkg::PH_CIDLE: begin
                        cnt_in = cnt_inc[swdh_pkg::CNT_W-1:0];
                        if (cnt_inc >= {1'b0, idle_bits}) begin
                           phase_in = swdh_pkg::PH_REQ;
                           cnt_in   = '0;
                        end
                     end
                  endcase
               end
            end
            swdh_pkg::OP_START, swdh_pkg::OP_CONNECT: begin
               busy = 1'b1;
               if (phase_ff == swdh_pkg::PH_IDLE) begin
                  attempt_in = '0;
                  cnt_in     = '0;
                  ack_in     = '0;
                  if (item.opcode == swdh_pkg::OP_START) begin
                     lat_ap_in    = item.ap_not_dp;
                     lat_read_in  = item.read_not_write;
                     lat_addr_in  = item.reg_addr;
                     lat_wdata_in = item.write_data;
                     phase_in     = swdh_pkg::PH_REQ;
                  end else begin
                     // Connect ends with a read of DPIDR (DP register 0).
                     lat_ap_in   = 1'b0;
                     lat_read_in = 1'b1;
                     lat_addr_in = 2'd0;
                     phase_in    = swdh_pkg::PH_LR1;
                  end
               end
            end
            default: begin
               busy = 1'b0;
            end
         endcase
      end
   end

   // Line outputs of the current phase.
   always_comb begin
      drive  = 1'b0;
      enable = 1'b0;
      unique case (phase_ff)
         swdh_pkg::PH_REQ: begin
            enable = 1'b1;
            drive  = req_byte[cnt_ff[2:0]];
         end
         swdh_pkg::PH_WDATA: begin
            enable = 1'b1;
            drive  = shift_ff[cnt_ff[4:0]];
         end
         swdh_pkg::PH_WPAR: begin
            enable = 1'b1;
            drive  = ^lat_wdata_ff;
         end
         swdh_pkg::PH_IDLEB, swdh_pkg::PH_CIDLE: begin
            enable = 1'b1;
         end
         swdh_pkg::PH_LR1, swdh_pkg::PH_LR2: begin
            enable = 1'b1;
            drive  = 1'b1;
         end
         swdh_pkg::PH_SWITCH: begin
            enable = 1'b1;
            drive  = swdh_pkg::SWITCH_WORD[cnt_ff[3:0]];
         end
         default: begin
            enable = 1'b0;
         end
      endcase
   end

   always_comb begin
      result.line_clocked = clocked;
      result.swdio_drive  = drive & clocked;
      result.swdio_enable = enable & clocked;
      result.busy_res     = busy;
      result.done_res     = done;
      result.status       = status_in;
      result.read_data    = last_read_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= swdh_pkg::PH_IDLE;
         cnt_ff       <= '0;
         shift_ff     <= '0;
         lat_ap_ff    <= 1'b0;
         lat_read_ff  <= 1'b0;
         lat_addr_ff  <= '0;
         lat_wdata_ff <= '0;
         ack_ff       <= '0;
         attempt_ff   <= '0;
         status_ff    <= swdh_pkg::ST_OK;
         last_read_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         shift_ff     <= shift_in;
         lat_ap_ff    <= lat_ap_in;
         lat_read_ff  <= lat_read_in;
         lat_addr_ff  <= lat_addr_in;
         lat_wdata_ff <= lat_wdata_in;
         ack_ff       <= ack_in;
         attempt_ff   <= attempt_in;
         status_ff    <= status_in;
         last_read_ff <= last_read_in;
      end
   end

endmodule

// File: design/swd_host_transfer_engine.sv
// Top level of the SWD host transfer engine: stream ports, settings registers
// and the result register. Depends on swdh_pkg and swdh_seq.
//
// Usage. Every transaction on the req_ channel is one item: a start of a DP/AP
// transfer, a start of the connect sequence (line reset, 0xE79E switch word,
// line reset, idle clocks, then a DPIDR read), or a tick that advances the
// wire by one SWCLK cycle when not idle. Every accepted item yields exactly one
// transaction on the rsp_ channel carrying the SWDIO level and enable for that
// cycle, busy and done flags, the last status and the last good read value.
// The csr_ channel writes retry_limit (index 0) and idle_bits (index 1); it is
// always ready and is meant to be written while no transfer is running.
//
// The result of an item accepted at one edge is registered and shown
// on rsp_ from the next cycle on. The sequencer step is a single pass of
// logic between the phase registers and the result register, so one item is
// accepted every cycle. When the receiver stalls, the result register holds
// its transaction and req_tready drops until that result is taken; while the
// result is being taken, a new item is accepted in the same cycle.
// Reset (synchronous, active high) returns the sequencer to idle, clears the
// status and read data, empties the result register and restores
// retry_limit to 64 and idle_bits to 8.
module swd_host_transfer_engine (
   input  logic        clock,
   input  logic        reset,
   // Request items.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata, from bit 0: ap_not_dp, read_not_write, reg_addr[1:0],
   // write_data[31:0], swdio_sample, zero fill [39:37].
   input  logic [39:0] req_tdata,
   // tuser: opcode[1:0].
   input  logic [1:0]  req_tuser,
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata, from bit 0: line_clocked, swdio_drive, swdio_enable, busy_res,
   // done_res, status[2:0], read_data[31:0].
   output logic [39:0] rsp_tdata,
   // Settings writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   logic [6:0]  retry_limit_ff, retry_limit_in;
   logic [7:0]  idle_bits_ff, idle_bits_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   swdh_pkg::item_type   item;
   swdh_pkg::result_type result;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      item.step           = req_accept;
      item.opcode         = req_tuser;
      item.ap_not_dp      = req_tdata[0];
      item.read_not_write = req_tdata[1];
      item.reg_addr       = req_tdata[3:2];
      item.write_data     = req_tdata[35:4];
      item.swdio_sample   = req_tdata[36];
   end

   swdh_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .item        (item),
      .retry_limit (retry_limit_ff),
      .idle_bits   (idle_bits_ff),
      .result      (result)
   );

   always_comb begin
      retry_limit_in = retry_limit_ff;
      idle_bits_in   = idle_bits_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            swdh_pkg::CSR_RETRY_LIMIT: retry_limit_in = csr_data[6:0];
            swdh_pkg::CSR_IDLE_BITS:   idle_bits_in   = csr_data;
         endcase
      end
   end

   // The result register refills on every accept and otherwise holds until taken.
   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = req_accept ? 40'(result) : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= swdh_pkg::RETRY_LIMIT_RESET;
         idle_bits_ff   <= swdh_pkg::IDLE_BITS_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         retry_limit_ff <= retry_limit_in;
         idle_bits_ff   <= idle_bits_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: design/swdh_checker.sv
// Port-level checks of the SWD host transfer engine, bound to the top level.
// Depends on swd_host_transfer_engine's ports only.
module swdh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // A stalled result keeps its transaction.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // A full, stalled result register blocks new items.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item accepted while result stalled");

   // Every accepted item produces a result in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item gave no result");

   // Without a clock cycle, swdio_drive and swdio_enable are both low.
   a_no_clock_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[2:1] == 2'b00)
      else $error("line activity without a clock cycle");

   // A completing tick is always a busy tick with a clock.
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[3] && rsp_tdata[0])
      else $error("done without busy clock");

endmodule

bind swd_host_transfer_engine swdh_checker u_swdh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
